FILE: rtl/vn_pkg.sv
// vn_pkg: shared constants for the vector normalizer.
// No dependencies; used by vn_root_lane and vector3_normalizer.
`timescale 1ns / 1ps
package vn_pkg;

  // Width of one component field on the stream ports
  localparam int FIELD_W = 32;

  // Headroom bits on the root datapath above the widest partial term
  localparam int ROOT_GUARD = 4;

endpackage

FILE: rtl/vn_root_lane.sv
// vn_root_lane: pipelined bit-serial scaled root for one component.
// q = largest value with q*q*sum <= sq * 2^(2*FB); one result bit per stage.
// Depends on vn_pkg.
`timescale 1ns / 1ps
module vn_root_lane #(
  parameter int CB = 32,
  parameter int FB = 30
) (
  input  logic              clk,
  input  logic              en,
  input  logic [2*CB-1:0]   sq,
  input  logic [2*CB-1:0]   sum,
  output logic [FB:0]       q
);

  localparam int SW    = 2 * CB;
  localparam int DW    = 2 * FB + SW + vn_pkg::ROOT_GUARD;
  localparam int STEPS = FB + 1;

  // Per stage: remainder T - q*q*S, running product q*S, partial root, sum
  logic [DW-1:0] rem_r  [STEPS];
  logic [DW-1:0] prod_r [STEPS];
  logic [DW-1:0] sum_r  [STEPS];
  logic [FB:0]   q_r    [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int B = FB - k;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] prod_in;
    logic [DW-1:0] sum_in;
    logic [FB:0]   q_in;
    logic [DW-1:0] delta;
    logic          take;

    // Stage inputs: target and sum at entry, previous stage otherwise
    if (k == 0) begin : g_first
      assign rem_in  = DW'(sq) << (2 * FB);
      assign prod_in = '0;
      assign sum_in  = DW'(sum);
      assign q_in    = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign prod_in = prod_r[k-1];
      assign sum_in  = sum_r[k-1];
      assign q_in    = q_r[k-1];
    end

    // Cost of setting bit B: (2^(B+1)*q + 2^(2B)) * S
    assign delta = (prod_in << (B + 1)) + (sum_in << (2 * B));
    assign take  = (delta <= rem_in);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? (rem_in - delta) : rem_in;
        prod_r[k] <= take ? (prod_in + (sum_in << B)) : prod_in;
        sum_r[k]  <= sum_in;
        q_r[k]    <= q_in | ({{FB{1'b0}}, take} << B);
      end
    end
  end

  assign q = q_r[STEPS-1];

endmodule

FILE: rtl/vector3_normalizer.sv
// vector3_normalizer: top level, scales a 3D integer vector to unit length.
// Depends on vn_pkg and vn_root_lane.
`timescale 1ns / 1ps
// Takes one vector beat per cycle while the output is not stalled, and returns
// one result beat per input, in order, through one input stage, one squaring
// stage, one sum stage, one root stage per result bit in each of three
// parallel lanes, and the output register.
// The pipeline advances whenever the output register is empty or being
// taken, so throughput is one vector per cycle unless out_tready stalls it.
// Results are Q1.FB values c/sqrt(S) truncated toward zero; a zero vector
// gives zeros with zero_length set.
module vector3_normalizer #(
  parameter int COMPONENT_BITS = 32,
  parameter int FRACTION_BITS  = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // comp_x [31:0], comp_y [63:32], comp_z [95:64]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // unit_x [31:0], unit_y [63:32], unit_z [95:64]
  output logic        out_tuser   // zero_length [0]
);

  localparam int CB  = COMPONENT_BITS;
  localparam int FB  = FRACTION_BITS;
  localparam int FW  = vn_pkg::FIELD_W;
  localparam int SW  = 2 * CB;
  localparam int LAT = FB + 1;

  logic en;

  // Stage 0: magnitude and sign
  logic          v0_r;
  logic [CB-1:0] mag0_r [3];
  logic [2:0]    neg0_r;
  // Stage 1: squares
  logic          v1_r;
  logic [SW-1:0] sq1_r  [3];
  logic [2:0]    neg1_r;
  // Stage 2: sum of squares
  logic          v2_r;
  logic [SW-1:0] sq2_r  [3];
  logic [SW-1:0] sum2_r;
  logic [2:0]    neg2_r;
  logic          zero2_r;
  // Side data riding beside the root lanes
  logic          vd_r    [LAT];
  logic [2:0]    negd_r  [LAT];
  logic          zerod_r [LAT];
  // Root results
  logic [FB:0]   root     [3];
  // Output register
  logic          out_tvalid_r;
  logic [95:0]   out_tdata_r;
  logic          out_tuser_r;
  logic [95:0]   out_tdata_nxt;

  // Whole pipeline moves when the output slot is free or being taken
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r         <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < LAT; i++) vd_r[i] <= 1'b0;
    end else if (en) begin
      v0_r         <= in_tvalid;
      v1_r         <= v0_r;
      v2_r         <= v1_r;
      vd_r[0]      <= v2_r;
      for (int i = 1; i < LAT; i++) vd_r[i] <= vd_r[i-1];
      out_tvalid_r <= vd_r[LAT-1];
    end
  end

  // Payload stages 0..2
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic [CB-1:0] raw;
        raw        = in_tdata[i*FW +: CB];
        neg0_r[i] <= raw[CB-1];
        mag0_r[i] <= raw[CB-1] ? (~raw + CB'(1)) : raw;
        sq1_r[i]  <= mag0_r[i] * mag0_r[i];
        sq2_r[i]  <= sq1_r[i];
      end
      neg1_r  <= neg0_r;
      neg2_r  <= neg1_r;
      sum2_r  <= sq1_r[0] + sq1_r[1] + sq1_r[2];
      zero2_r <= (sq1_r[0] == '0) && (sq1_r[1] == '0) && (sq1_r[2] == '0);
    end
  end

  // Side data delay line
  always_ff @(posedge clk) begin
    if (en) begin
      negd_r[0]  <= neg2_r;
      zerod_r[0] <= zero2_r;
      for (int i = 1; i < LAT; i++) begin
        negd_r[i]  <= negd_r[i-1];
        zerod_r[i] <= zerod_r[i-1];
      end
    end
  end

  // Three root lanes
  for (genvar l = 0; l < 3; l++) begin : g_lane
    vn_root_lane #(
      .CB (CB),
      .FB (FB)
    ) u_lane (
      .clk (clk),
      .en  (en),
      .sq  (sq2_r[l]),
      .sum (sum2_r),
      .q   (root[l])
    );
  end

  // Sign restore and zero vector override
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [FW-1:0] mag;
      mag = FW'(root[i]);
      if (zerod_r[LAT-1]) begin
        out_tdata_nxt[i*FW +: FW] = '0;
      end else begin
        out_tdata_nxt[i*FW +: FW] = negd_r[LAT-1][i] ? (~mag + FW'(1)) : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= zerod_r[LAT-1];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Checks
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("zero vector result carries nonzero components");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[31:0]) <= $signed(33'(2**FB)))
                && ($signed(out_tdata[31:0]) >= -$signed(33'(2**FB))))
    else $error("unit_x outside unit range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule
